/* hw/rtl/hhg_pkg.sv */
// Shared types and constants for the homology hit grouper.
package hhg_pkg;

  localparam int CFG_BITS = 30;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SOURCE_GAP      = 2'd0,
    CFG_MITO_GAP        = 2'd1,
    CFG_WIDE_SOURCE_GAP = 2'd2,
    CFG_WIDE_MITO_GAP   = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_BITS-1:0] RST_SOURCE_GAP      = 30'd5000;
  localparam logic [CFG_BITS-1:0] RST_MITO_GAP        = 30'd100;
  localparam logic [CFG_BITS-1:0] RST_WIDE_SOURCE_GAP = 30'd20000;
  localparam logic [CFG_BITS-1:0] RST_WIDE_MITO_GAP   = 30'd100;

  // Joining limits as held by the top level and used by the join test.
  typedef struct packed {
    logic [CFG_BITS-1:0] source_gap;
    logic [CFG_BITS-1:0] mito_gap;
    logic [CFG_BITS-1:0] wide_source_gap;
    logic [CFG_BITS-1:0] wide_mito_gap;
  } limits_t;

  // Result queue depth; one accepted hit can push two entries.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

endpackage

/* hw/rtl/hhg_if.sv */
// Valid/ready channel interfaces for hits and group results.
interface hhg_in_if #(
  parameter int COORD_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] mito_begin;
  logic [COORD_BITS-1:0] mito_end;
  logic [COORD_BITS-1:0] src_begin;
  logic [COORD_BITS-1:0] src_end;
  logic                  last_in_set;

  modport source (output valid, mito_begin, mito_end, src_begin, src_end, last_in_set,
                  input ready);
  modport sink (input valid, mito_begin, mito_end, src_begin, src_end, last_in_set,
                output ready);
endinterface

interface hhg_out_if #(
  parameter int COORD_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] group_start;
  logic [COORD_BITS-1:0] group_stop;
  logic                  last_of_run;

  modport source (output valid, group_start, group_stop, last_of_run, input ready);
  modport sink (input valid, group_start, group_stop, last_of_run, output ready);
endinterface

/* hw/rtl/hhg_join.sv */
// Joining test of one hit against the tail of the open group.
module hhg_join
  import hhg_pkg::*;
#(
  parameter int COORD_BITS = 30
) (
  input  limits_t               limits,
  input  logic [COORD_BITS-1:0] tail_mito_begin,
  input  logic [COORD_BITS-1:0] tail_mito_end,
  input  logic [COORD_BITS-1:0] tail_src_end,
  input  logic [COORD_BITS-1:0] mito_begin,
  input  logic [COORD_BITS-1:0] mito_end,
  input  logic [COORD_BITS-1:0] src_begin,
  output logic                  joins
);

  // Two spare bits keep every difference and limit exact as a signed value.
  localparam int DW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

  logic signed [DW-1:0] tme_s, mb_s, sb_s, tse_s;
  logic signed [DW-1:0] src_gap_s, mito_gap_s, wide_src_s, wide_mito_s;
  logic signed [DW-1:0] d, g_rev, g_fwd;
  logic rev, fwd, plain_ok, rev_ok, fwd_ok, wide_src_ok;

  assign tme_s = $signed({{(DW-COORD_BITS){1'b0}}, tail_mito_end});
  assign mb_s  = $signed({{(DW-COORD_BITS){1'b0}}, mito_begin});
  assign sb_s  = $signed({{(DW-COORD_BITS){1'b0}}, src_begin});
  assign tse_s = $signed({{(DW-COORD_BITS){1'b0}}, tail_src_end});

  assign src_gap_s   = $signed({{(DW-CFG_BITS){1'b0}}, limits.source_gap});
  assign mito_gap_s  = $signed({{(DW-CFG_BITS){1'b0}}, limits.mito_gap});
  assign wide_src_s  = $signed({{(DW-CFG_BITS){1'b0}}, limits.wide_source_gap});
  assign wide_mito_s = $signed({{(DW-CFG_BITS){1'b0}}, limits.wide_mito_gap});

  assign d     = sb_s - tse_s;
  assign g_rev = tme_s - mb_s;
  assign g_fwd = mb_s - tme_s;

  assign rev = (tail_mito_begin > tail_mito_end) && (mito_begin > mito_end);
  assign fwd = (tail_mito_begin < tail_mito_end) && (mito_begin < mito_end);

  assign plain_ok    = d < src_gap_s;
  assign wide_src_ok = d < wide_src_s;

  assign rev_ok = ((tail_mito_end < mito_begin) && (tail_mito_end > mito_end))
               || ((g_rev > 0) && (g_rev < mito_gap_s))
               || (wide_src_ok && (g_rev < wide_mito_s));

  assign fwd_ok = ((tail_mito_end > mito_begin) && (tail_mito_end < mito_end))
               || ((g_fwd > 0) && (g_fwd < mito_gap_s))
               || (wide_src_ok && (g_fwd < wide_mito_s));

  assign joins = plain_ok || (rev && rev_ok) || (fwd && fwd_ok);

endmodule

/* hw/rtl/hhg_out_fifo.sv */
// Result queue taking up to two results per cycle; pops one when ready.
module hhg_out_fifo
  import hhg_pkg::*;
#(
  parameter int COORD_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_cnt,
  input  logic [COORD_BITS-1:0] start0,
  input  logic [COORD_BITS-1:0] stop0,
  input  logic                  last0,
  input  logic [COORD_BITS-1:0] start1,
  input  logic [COORD_BITS-1:0] stop1,
  output logic                  room2,
  hhg_out_if.source             out_ch
);

  logic [COORD_BITS-1:0] start_r [OUT_DEPTH];
  logic [COORD_BITS-1:0] stop_r  [OUT_DEPTH];
  logic                  last_r  [OUT_DEPTH];

  logic [OUT_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [OUT_PTR_BITS:0]   count_r, count_nxt;
  logic                    pop;

  assign pop        = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1  = wr_ptr_r + OUT_PTR_BITS'(1);
  assign wr_ptr_nxt = wr_ptr_r + OUT_PTR_BITS'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + OUT_PTR_BITS'(pop);
  assign count_nxt  = count_r + (OUT_PTR_BITS+1)'(push_cnt) - (OUT_PTR_BITS+1)'(pop);

  assign room2 = count_r <= (OUT_PTR_BITS+1)'(OUT_DEPTH - 2);

  assign out_ch.valid       = count_r != '0;
  assign out_ch.group_start = start_r[rd_ptr_r];
  assign out_ch.group_stop  = stop_r[rd_ptr_r];
  assign out_ch.last_of_run = last_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      start_r[wr_ptr_r] <= start0;
      stop_r[wr_ptr_r]  <= stop0;
      last_r[wr_ptr_r]  <= last0;
    end
    if (push_cnt == 2'd2) begin
      start_r[wr_ptr_p1] <= start1;
      stop_r[wr_ptr_p1]  <= stop1;
      last_r[wr_ptr_p1]  <= 1'b1;
    end
  end

endmodule

/* hw/rtl/homology_hit_grouper.sv */
// A group result is written into the result queue when the hit that closes it is accepted.
// Throughput: one hit per cycle while hits close at most one group each and the output is
// ready; a hit that yields two results needs one beat of the single-beat output port for each.
// The four-entry result queue accepts a hit whenever two entries are free.
// Synchronous active-low reset: limits return to defaults, no group is open, queue empties.
module homology_hit_grouper
  import hhg_pkg::*;
#(
  parameter int COORD_BITS = 30
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_BITS-1:0]     cfg_data,
  hhg_in_if.sink                  in_ch,
  hhg_out_if.source               out_ch
);

  limits_t               limits_r;
  logic                  group_open_r;
  logic [COORD_BITS-1:0] open_src_begin_r;
  logic [COORD_BITS-1:0] tail_mito_begin_r;
  logic [COORD_BITS-1:0] tail_mito_end_r;
  logic [COORD_BITS-1:0] tail_src_end_r;

  logic                  joins, accept, joined, close_old, room2;
  logic [1:0]            push_cnt;
  logic [COORD_BITS-1:0] new_start, start0, stop0;
  logic                  last0;

  hhg_join #(.COORD_BITS(COORD_BITS)) u_join (
    .limits          (limits_r),
    .tail_mito_begin (tail_mito_begin_r),
    .tail_mito_end   (tail_mito_end_r),
    .tail_src_end    (tail_src_end_r),
    .mito_begin      (in_ch.mito_begin),
    .mito_end        (in_ch.mito_end),
    .src_begin       (in_ch.src_begin),
    .joins           (joins)
  );

  assign in_ch.ready = room2;
  assign accept      = in_ch.valid && in_ch.ready;
  assign joined      = group_open_r && joins;
  assign close_old   = group_open_r && !joins;

  // The group the hit ends up in: the open one if it joined, else its own.
  assign new_start = joined ? open_src_begin_r : in_ch.src_begin;

  // With an old group closing, it goes first and the flushed group, if any, second.
  always_comb begin
    push_cnt = 2'd0;
    start0   = new_start;
    stop0    = in_ch.src_end;
    last0    = 1'b1;
    if (accept) begin
      if (close_old) begin
        start0   = open_src_begin_r;
        stop0    = tail_src_end_r;
        last0    = !in_ch.last_in_set;
        push_cnt = in_ch.last_in_set ? 2'd2 : 2'd1;
      end else begin
        push_cnt = in_ch.last_in_set ? 2'd1 : 2'd0;
      end
    end
  end

  hhg_out_fifo #(.COORD_BITS(COORD_BITS)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .start0   (start0),
    .stop0    (stop0),
    .last0    (last0),
    .start1   (new_start),
    .stop1    (in_ch.src_end),
    .room2    (room2),
    .out_ch   (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.source_gap      <= RST_SOURCE_GAP;
      limits_r.mito_gap        <= RST_MITO_GAP;
      limits_r.wide_source_gap <= RST_WIDE_SOURCE_GAP;
      limits_r.wide_mito_gap   <= RST_WIDE_MITO_GAP;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SOURCE_GAP:      limits_r.source_gap      <= cfg_data;
        CFG_MITO_GAP:        limits_r.mito_gap        <= cfg_data;
        CFG_WIDE_SOURCE_GAP: limits_r.wide_source_gap <= cfg_data;
        CFG_WIDE_MITO_GAP:   limits_r.wide_mito_gap   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r      <= 1'b0;
      open_src_begin_r  <= '0;
      tail_mito_begin_r <= '0;
      tail_mito_end_r   <= '0;
      tail_src_end_r    <= '0;
    end else if (accept) begin
      group_open_r      <= !in_ch.last_in_set;
      open_src_begin_r  <= new_start;
      tail_mito_begin_r <= in_ch.mito_begin;
      tail_mito_end_r   <= in_ch.mito_end;
      tail_src_end_r    <= in_ch.src_end;
    end
  end

endmodule

/* verif/hhg_group_checker.sv */
// Checker for the hit grouper: predicts group results from accepted hits and compares them.
`timescale 1ns / 100ps

module hhg_group_checker
  import hhg_pkg::*;
#(
  parameter int COORD_BITS = 30
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_BITS-1:0]     cfg_data,
  hhg_in_if                       hits,
  hhg_out_if                      groups,
  output int                      mismatches,
  output int                      awaiting,
  output int                      groups_checked
);

  typedef struct packed {
    logic [COORD_BITS-1:0] start;
    logic [COORD_BITS-1:0] stop;
    logic                  last;
  } group_t;

  limits_t               lim;
  logic                  grp_open;
  logic [COORD_BITS-1:0] grp_start;
  logic [COORD_BITS-1:0] tail_mb;
  logic [COORD_BITS-1:0] tail_me;
  logic [COORD_BITS-1:0] tail_se;
  group_t                expected_groups[$];

  // All differences are taken as signed 64-bit values so that gaps can go negative.
  function automatic bit hit_joins(longint mb, longint me, longint sb);
    longint tmb, tme, d, g;
    longint src_lim, mito_lim, wide_src_lim, wide_mito_lim;
    tmb = longint'(tail_mb);
    tme = longint'(tail_me);
    src_lim = longint'(lim.source_gap);
    mito_lim = longint'(lim.mito_gap);
    wide_src_lim = longint'(lim.wide_source_gap);
    wide_mito_lim = longint'(lim.wide_mito_gap);
    d = sb - longint'(tail_se);
    if (d < src_lim) return 1'b1;
    if (tmb > tme && mb > me) begin
      g = tme - mb;
      if (tme < mb && tme > me) return 1'b1;
      if (g > 0 && g < mito_lim) return 1'b1;
      if (d < wide_src_lim && g < wide_mito_lim) return 1'b1;
    end
    if (tmb < tme && mb < me) begin
      g = mb - tme;
      if (tme > mb && tme < me) return 1'b1;
      if (g > 0 && g < mito_lim) return 1'b1;
      if (d < wide_src_lim && g < wide_mito_lim) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [COORD_BITS-1:0] got,
                                 logic [COORD_BITS-1:0] want);
    mismatches++;
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    group_t want;
    int     n;
    if (!rst_n) begin
      lim.source_gap = RST_SOURCE_GAP;
      lim.mito_gap = RST_MITO_GAP;
      lim.wide_source_gap = RST_WIDE_SOURCE_GAP;
      lim.wide_mito_gap = RST_WIDE_MITO_GAP;
      grp_open = 1'b0;
      grp_start = '0;
      tail_mb = '0;
      tail_me = '0;
      tail_se = '0;
      expected_groups.delete();
      mismatches = 0;
      groups_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SOURCE_GAP:      lim.source_gap = cfg_data;
          CFG_MITO_GAP:        lim.mito_gap = cfg_data;
          CFG_WIDE_SOURCE_GAP: lim.wide_source_gap = cfg_data;
          CFG_WIDE_MITO_GAP:   lim.wide_mito_gap = cfg_data;
          default: ;
        endcase
      end

      if (hits.valid && hits.ready) begin
        n = 0;
        if (!(grp_open && hit_joins(longint'(hits.mito_begin), longint'(hits.mito_end),
                                    longint'(hits.src_begin)))) begin
          // A hit that fails the test closes the open group and starts its own.
          if (grp_open) begin
            expected_groups.push_back('{grp_start, tail_se, 1'b0});
            n++;
          end
          grp_open = 1'b1;
          grp_start = hits.src_begin;
        end
        tail_mb = hits.mito_begin;
        tail_me = hits.mito_end;
        tail_se = hits.src_end;
        if (hits.last_in_set) begin
          expected_groups.push_back('{grp_start, tail_se, 1'b0});
          n++;
          grp_open = 1'b0;
        end
        if (n > 0) expected_groups[expected_groups.size()-1].last = 1'b1;
      end

      if (groups.valid && groups.ready) begin
        groups_checked++;
        if (expected_groups.size() == 0) begin
          report_mismatch("group_start of an unexpected beat", groups.group_start, '0);
        end else begin
          want = expected_groups.pop_front();
          if (groups.group_start !== want.start)
            report_mismatch("group_start", groups.group_start, want.start);
          if (groups.group_stop !== want.stop)
            report_mismatch("group_stop", groups.group_stop, want.stop);
          if (groups.last_of_run !== want.last)
            report_mismatch("last_of_run", groups.last_of_run, want.last);
        end
      end
    end
    awaiting <= expected_groups.size();
  end

endmodule

/* verif/homology_hit_grouper_tb.sv */
// Top of the hit grouper testbench: clock, reset, hit stimulus, limit settings and verdict.
`timescale 1ns / 100ps

module homology_hit_grouper_tb;
  import hhg_pkg::*;

  localparam int          COORD_BITS   = 30;
  localparam longint      COORD_TOP    = (64'd1 << COORD_BITS) - 1;
  localparam int unsigned COORD_TOP_U  = 32'(COORD_TOP);
  localparam int          RANDOM_HITS  = 1430;
  localparam int          PHASES       = 10;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [COORD_BITS-1:0] mito_begin;
    logic [COORD_BITS-1:0] mito_end;
    logic [COORD_BITS-1:0] src_begin;
    logic [COORD_BITS-1:0] src_end;
    logic                  last_in_set;
  } hit_t;

  typedef enum logic [1:0] {
    DIR_FWD,
    DIR_REV,
    DIR_FLAT
  } dir_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [CFG_BITS-1:0] cfg_data;
  logic                sink_ready = 1'b0;
  bit                  calm = 1'b0;
  int                  rx_hold = 0;
  int                  idle_cycles = 0;
  int                  hits_sent = 0;
  int                  mismatches;
  int                  awaiting;
  int                  groups_checked;

  // Shaping state for the random sets: current limits and the last hit driven.
  limits_t               lim;
  logic [COORD_BITS-1:0] prev_me;
  logic [COORD_BITS-1:0] prev_se;
  int                    set_left = 0;
  dir_t                  set_dir = DIR_FWD;
  hit_t                  opening[$];

  hhg_in_if  #(.COORD_BITS(COORD_BITS)) hit_ch ();
  hhg_out_if #(.COORD_BITS(COORD_BITS)) group_ch ();

  assign group_ch.ready = sink_ready;

  homology_hit_grouper #(.COORD_BITS(COORD_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (hit_ch),
    .out_ch   (group_ch)
  );

  hhg_group_checker #(.COORD_BITS(COORD_BITS)) group_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .hits           (hit_ch),
    .groups         (group_ch),
    .mismatches     (mismatches),
    .awaiting       (awaiting),
    .groups_checked (groups_checked)
  );

  always #1 clk = ~clk;

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic hit_t mk(longint mb, longint me, longint sb, longint se, longint last);
    return '{mb[COORD_BITS-1:0], me[COORD_BITS-1:0], sb[COORD_BITS-1:0],
             se[COORD_BITS-1:0], last[0]};
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    if (v < 1) return COORD_BITS'(1);
    if (v > COORD_TOP) return COORD_TOP[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  // A value within three of a limit, so both sides of each compare get hit.
  function automatic longint near(logic [CFG_BITS-1:0] bound);
    return longint'(bound) + longint'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic logic [CFG_BITS-1:0] rand_limit();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1:       return CFG_BITS'($urandom_range(0, 200));
      2:       return CFG_BITS'($urandom_range(0, 50000));
      default: return CFG_BITS'($urandom_range(0, COORD_TOP_U));
    endcase
  endfunction

  // Receiver: after each accepted result beat it may hold ready low for a drawn count.
  always @(posedge clk) begin : result_sink
    int hold;
    if (!rst_n) begin
      sink_ready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      sink_ready <= (rx_hold == 1);
    end else if (group_ch.valid && sink_ready) begin
      hold = draw_wait();
      rx_hold <= hold;
      sink_ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (hit_ch.valid && hit_ch.ready) || (group_ch.valid && group_ch.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_hit(hit_t h);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.mito_begin <= h.mito_begin;
    hit_ch.mito_end <= h.mito_end;
    hit_ch.src_begin <= h.src_begin;
    hit_ch.src_end <= h.src_end;
    hit_ch.last_in_set <= h.last_in_set;
    do @(posedge clk); while (!hit_ch.ready);
    hits_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Limits change only once the block has drained every result.
  task automatic apply_limits(limits_t l);
    hit_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_SOURCE_GAP, l.source_gap);
    write_reg(CFG_MITO_GAP, l.mito_gap);
    write_reg(CFG_WIDE_SOURCE_GAP, l.wide_source_gap);
    write_reg(CFG_WIDE_MITO_GAP, l.wide_mito_gap);
    cfg_we <= 1'b0;
    lim = l;
  endtask

  // Mostly sorted sets whose source and mito gaps sit around the current limits,
  // with about one hit in ten of pure noise.
  task automatic next_random_hit(output hit_t h);
    longint d, g, mb, me, sb, se, pme, pse;
    dir_t   dir;
    bit     overlap;
    if (set_left == 0) begin
      set_left = $urandom_range(1, 12);
      if ($urandom_range(0, 15) == 0) set_dir = DIR_FLAT;
      else set_dir = $urandom_range(0, 1) ? DIR_FWD : DIR_REV;
      prev_se = COORD_BITS'($urandom_range(0, 1) ? $urandom_range(1, 100000)
                                                 : $urandom_range(1, COORD_TOP_U));
      prev_me = COORD_BITS'($urandom_range(0, 1) ? $urandom_range(1, 100000)
                                                 : $urandom_range(1, COORD_TOP_U));
    end
    if ($urandom_range(0, 9) == 0) begin
      h.mito_begin = COORD_BITS'($urandom_range(1, COORD_TOP_U));
      h.mito_end = COORD_BITS'($urandom_range(1, COORD_TOP_U));
      h.src_begin = COORD_BITS'($urandom_range(1, COORD_TOP_U));
      h.src_end = COORD_BITS'($urandom_range(1, COORD_TOP_U));
      h.last_in_set = ($urandom_range(0, 1) == 1);
    end else begin
      pme = longint'(prev_me);
      pse = longint'(prev_se);
      case ($urandom_range(0, 5))
        0:       d = near(lim.source_gap);
        1:       d = near(lim.wide_source_gap);
        2:       d = longint'($urandom_range(0, 30000));
        3:       d = -longint'($urandom_range(1, 5000));
        4:       d = longint'($urandom_range(0, 2000));
        default: d = longint'($urandom_range(0, COORD_TOP_U));
      endcase
      overlap = 1'b0;
      case ($urandom_range(0, 6))
        0:       g = near(lim.mito_gap);
        1:       g = near(lim.wide_mito_gap);
        2:       g = longint'($urandom_range(1, 150));
        3:       g = -longint'($urandom_range(0, 300));
        4:       overlap = 1'b1;
        5:       g = 0;
        default: g = longint'($urandom_range(0, COORD_TOP_U));
      endcase
      dir = ($urandom_range(0, 5) == 0) ? dir_t'($urandom_range(0, 2)) : set_dir;
      case (dir)
        DIR_FWD: begin
          if (overlap) begin
            mb = pme - longint'($urandom_range(1, 500));
            me = pme + longint'($urandom_range(1, 500));
          end else begin
            mb = pme + g;
            me = mb + longint'($urandom_range(1, 2000));
          end
        end
        DIR_REV: begin
          if (overlap) begin
            mb = pme + longint'($urandom_range(1, 500));
            me = pme - longint'($urandom_range(1, 500));
          end else begin
            mb = pme - g;
            me = mb - longint'($urandom_range(1, 2000));
          end
        end
        default: begin
          mb = longint'($urandom_range(1, COORD_TOP_U));
          me = mb;
        end
      endcase
      sb = pse + d;
      se = sb + longint'($urandom_range(0, 3000));
      h.mito_begin = clamp_coord(mb);
      h.mito_end = clamp_coord(me);
      h.src_begin = clamp_coord(sb);
      h.src_end = clamp_coord(se);
      h.last_in_set = (set_left == 1);
      set_left--;
    end
    prev_me = h.mito_end;
    prev_se = h.src_end;
  endtask

  initial begin
    limits_t l;
    hit_t    h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SOURCE_GAP;
    cfg_data = '0;
    hit_ch.valid = 1'b0;
    hit_ch.mito_begin = '0;
    hit_ch.mito_end = '0;
    hit_ch.src_begin = '0;
    hit_ch.src_end = '0;
    hit_ch.last_in_set = 1'b0;
    lim = '{RST_SOURCE_GAP, RST_MITO_GAP, RST_WIDE_SOURCE_GAP, RST_WIDE_MITO_GAP};
    prev_me = '0;
    prev_se = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed hits under the reset limits.
    opening.push_back(mk(10, 20, 100, 200, 1));               // set of one hit
    opening.push_back(mk(1000, 2000, 1000, 1500, 0));
    opening.push_back(mk(1900, 2500, 100000, 100500, 0));     // forward overlap
    opening.push_back(mk(2550, 2700, 300000, 300100, 0));     // forward mito gap
    opening.push_back(mk(2600, 2650, 310100, 310200, 0));     // forward wide test
    opening.push_back(mk(5000, 4000, 400000, 400100, 0));     // orientation change
    opening.push_back(mk(4500, 3500, 500000, 500100, 0));     // reverse overlap
    opening.push_back(mk(3450, 3000, 600000, 600100, 0));     // reverse mito gap
    opening.push_back(mk(3100, 3050, 610100, 610200, 0));     // reverse wide test
    opening.push_back(mk(2950, 2900, 700000, 700100, 0));     // mito gap at the limit
    opening.push_back(mk(2000, 2000, 705099, 705200, 0));     // flat, source gap below
    opening.push_back(mk(2500, 2500, 710200, 710300, 0));     // flat, source gap at limit
    opening.push_back(mk(1, 2, 5, 10, 0));                    // source start out of order
    opening.push_back(mk(1000, 1100, 100000, 100100, 1));     // rejected final hit
    opening.push_back(mk(COORD_TOP, 1, 1, COORD_TOP, 0));
    opening.push_back(mk(1, COORD_TOP, COORD_TOP, COORD_TOP, 1));
    opening.push_back(mk(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1));
    opening.push_back(mk('h2AAAAAAA, 'h15555555, 'h15555555, 'h2AAAAAAA, 0));
    opening.push_back(mk('h15555555, 'h2AAAAAAA, 'h2AAAAAAA, 'h15555555, 1));
    foreach (opening[i]) send_hit(opening[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: l = '{RST_SOURCE_GAP, RST_MITO_GAP, RST_WIDE_SOURCE_GAP, RST_WIDE_MITO_GAP};
        1: l = '0;
        2: l = '1;
        3: l = '{CFG_BITS'(50), CFG_BITS'(10), CFG_BITS'(500), CFG_BITS'(40)};
        4: l = '{'0, '1, '0, '1};
        default: l = '{rand_limit(), rand_limit(), rand_limit(), rand_limit()};
      endcase
      apply_limits(l);
      set_left = 0;
      for (int i = 0; i < RANDOM_HITS / PHASES; i++) begin
        // Some stretches run with no gaps on either channel.
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        next_random_hit(h);
        send_hit(h);
      end
    end

    hit_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d hits (%0d directed) over %0d limit settings; checked %0d group results.",
             hits_sent, opening.size(), PHASES + 1, groups_checked);
    $display("Random sets covered forward, reverse and flat mito pairs around each limit.");
    if (mismatches == 0 && awaiting == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d group results still expected", mismatches, awaiting);
      $display("status: fail");
    end
    $finish;
  end

endmodule
